/* sv/prime_generator_trial_division_macros.svh */
// assertion macros for the prime generator rtl
`ifndef PRIME_GENERATOR_TRIAL_DIVISION_MACROS_SVH
`define PRIME_GENERATOR_TRIAL_DIVISION_MACROS_SVH

`ifndef ASSERT_OFF
`define PTD_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define PTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define PTD_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define PTD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

/* sv/ptd_pkg.sv */
package ptd_pkg;

   localparam int LIMIT_W         = 24;
   localparam int DIGIT_W         = 4;
   localparam int FIRST_CANDIDATE = 7;
   localparam int LIMIT_RESET     = 100;

   localparam logic [1:0]         SEED_COUNT   = 2'd3;
   localparam logic [DIGIT_W-1:0] DIGIT_ONE    = 4'd1;
   localparam logic [DIGIT_W-1:0] DIGIT_THREE  = 4'd3;
   localparam logic [DIGIT_W-1:0] DIGIT_SEVEN  = 4'd7;
   localparam logic [DIGIT_W-1:0] DIGIT_NINE   = 4'd9;
   localparam logic [DIGIT_W-1:0] DIGIT_STEP   = 4'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_CHECK,
      ST_TEST,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic valid;
      logic zero;
      logic busy;
   } chain_status_type;

   function automatic logic [2:0] seed_prime(input logic [1:0] idx);
      logic [2:0] value;
      case (idx)
         2'd0: value = 3'd2;
         2'd1: value = 3'd3;
         2'd2: value = 3'd5;
         default: value = 3'd0;
      endcase
      return value;
   endfunction

endpackage

/* sv/ptd_div_cell.sv */
module ptd_div_cell #(
   parameter int WIDTH = 24
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             dividend_bit,
   input  logic             in_valid,
   input  logic [WIDTH-1:0] in_divisor,
   input  logic [WIDTH-1:0] in_rem,
   output logic             out_valid_ff,
   output logic [WIDTH-1:0] out_divisor_ff,
   output logic [WIDTH-1:0] out_rem_ff
);

   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;
   logic [WIDTH-1:0] rem_in;

   always_comb begin
      shifted = {in_rem, dividend_bit};
      diff    = shifted - {1'b0, in_divisor};
      if (diff[WIDTH]) begin
         rem_in = shifted[WIDTH-1:0];
      end else begin
         rem_in = diff[WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= in_valid;
      end
      out_divisor_ff <= in_divisor;
      out_rem_ff     <= rem_in;
   end

endmodule

/* sv/ptd_div_chain.sv */
module ptd_div_chain #(
   parameter int WIDTH = 24
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [WIDTH-1:0]          dividend,
   input  logic                      in_valid,
   input  logic [WIDTH-1:0]          in_divisor,
   output ptd_pkg::chain_status_type status
);

   import ptd_pkg::*;

   logic [WIDTH:0]   vld;
   logic [WIDTH-1:0] dvs [0:WIDTH];
   logic [WIDTH-1:0] rem [0:WIDTH];

   assign vld[0] = in_valid;
   assign dvs[0] = in_divisor;
   assign rem[0] = '0;

   for (genvar k = 0; k < WIDTH; k++) begin : g_cell
      ptd_div_cell #(
         .WIDTH(WIDTH)
      ) u_cell (
         .clock         (clock),
         .reset         (reset),
         .dividend_bit  (dividend[WIDTH-1-k]),
         .in_valid      (vld[k]),
         .in_divisor    (dvs[k]),
         .in_rem        (rem[k]),
         .out_valid_ff  (vld[k+1]),
         .out_divisor_ff(dvs[k+1]),
         .out_rem_ff    (rem[k+1])
      );
   end

   always_comb begin
      status.valid = vld[WIDTH];
      status.zero  = (rem[WIDTH] == '0) && (dvs[WIDTH] != '0);
      status.busy  = |vld[WIDTH:1];
   end

endmodule

/* sv/prime_generator_trial_division.sv */
// Trial-division prime generator. Each request item gives the next prime in ascending
// order; restart set in the request starts over at 2. The first three answers are the
// seeds 2, 3 and 5. For each later candidate the seed primes and the prime table memory
// feed one divisor per cycle into a chain of NUMBER_WIDTH remainder cells, stopping once
// a divisor divides it or passes its square root; the chain must drain before the verdict.
// One request walks as many candidates as lie between two primes. Primes are stored until
// the table holds TABLE_DEPTH entries; no clearing pass is needed after reset. Once a
// candidate reaches search_limit every answer is 0 with finished set until a restart.
`include "prime_generator_trial_division_macros.svh"

module prime_generator_trial_division #(
   parameter int TABLE_DEPTH  = 1024,
   parameter int NUMBER_WIDTH = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [23:0] csr_wr_data,  // search_limit
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // restart, zero fill
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // prime_value
   output logic [0:0]  rsp_tuser     // finished
);

   import ptd_pkg::*;

   localparam int W      = NUMBER_WIDTH;
   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int ADDR_W = $clog2(TABLE_DEPTH);
   localparam int WIDE_W = (W > LIMIT_W) ? W : LIMIT_W;

   state_type           state_ff, state_in;
   logic [1:0]          seed_ff, seed_in;
   logic                done_ff, done_in;
   logic [W-1:0]        cand_ff, cand_in;
   logic [DIGIT_W-1:0]  digit_ff, digit_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    rd_idx_ff, rd_idx_in;
   logic                stop_ff, stop_in;
   logic                found_ff, found_in;
   logic [LIMIT_W-1:0]  res_prime_ff, res_prime_in;
   logic                res_fin_ff, res_fin_in;
   logic [LIMIT_W-1:0]  limit_ff;
   logic                valid_b_ff;
   logic [1:0]          seed_sel_b_ff, seed_sel;
   logic [W-1:0]        mem_rd_ff;
   logic                valid_c_ff;
   logic [W-1:0]        p_c_ff;
   logic [2*W-1:0]      sq_c_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LIMIT_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                rsp_fin_ff, rsp_fin_in;

   logic [W-1:0]        mem [0:TABLE_DEPTH-1];
   logic                tbl_wr_en;
   logic                issue;
   logic                pipe_empty;
   logic                chain_in_valid;
   logic                sq_over;
   logic [W-1:0]        p_b;
   logic [W:0]          cand_sum;
   logic [W-1:0]        cand_next;
   logic [DIGIT_W-1:0]  digit_next;
   logic [WIDE_W-1:0]   cand_wide;
   logic [WIDE_W-1:0]   limit_wide;
   chain_status_type    chain_status;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_fin_ff;

   always_comb begin
      cand_wide  = WIDE_W'(cand_ff);
      limit_wide = WIDE_W'(limit_ff);
      seed_sel   = (rd_idx_ff == CNT_W'(1)) ? 2'd1 :
                   (rd_idx_ff == CNT_W'(2)) ? 2'd2 : 2'd0;
      p_b        = (seed_sel_b_ff != 2'd0) ? W'(seed_prime(seed_sel_b_ff)) : mem_rd_ff;
      sq_over    = sq_c_ff > {{W{1'b0}}, cand_ff};
      chain_in_valid = valid_c_ff && !stop_ff && !sq_over;
      issue      = (state_ff == ST_TEST) && (rd_idx_ff < count_ff) && !stop_ff && !found_ff;
      pipe_empty = !valid_b_ff && !valid_c_ff && !chain_status.busy;
      cand_sum   = {1'b0, cand_ff} + ((digit_ff == DIGIT_THREE) ? (W+1)'(4) : (W+1)'(2));
      cand_next  = cand_sum[W] ? {W{1'b1}} : cand_sum[W-1:0];
      if (digit_ff == DIGIT_THREE) begin
         digit_next = DIGIT_SEVEN;
      end else if (digit_ff == DIGIT_NINE) begin
         digit_next = DIGIT_ONE;
      end else begin
         digit_next = digit_ff + DIGIT_STEP;
      end
   end

   always_comb begin
      state_in     = state_ff;
      seed_in      = seed_ff;
      done_in      = done_ff;
      cand_in      = cand_ff;
      digit_in     = digit_ff;
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      stop_in      = stop_ff;
      found_in     = found_ff;
      res_prime_in = res_prime_ff;
      res_fin_in   = res_fin_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_fin_in   = rsp_fin_ff;
      tbl_wr_en    = 1'b0;

      if (valid_c_ff && sq_over) begin
         stop_in = 1'b1;
      end
      if (chain_status.valid && chain_status.zero) begin
         found_in = 1'b1;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_tdata[0]) begin
                  seed_in  = 2'd0;
                  done_in  = 1'b0;
                  cand_in  = W'(FIRST_CANDIDATE);
                  digit_in = DIGIT_SEVEN;
                  count_in = CNT_W'(SEED_COUNT);
               end
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (seed_ff < SEED_COUNT) begin
               res_prime_in = LIMIT_W'(seed_prime(seed_ff));
               res_fin_in   = 1'b0;
               seed_in      = seed_ff + 2'd1;
               state_in     = ST_EMIT;
            end else if (done_ff) begin
               res_prime_in = '0;
               res_fin_in   = 1'b1;
               state_in     = ST_EMIT;
            end else begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (cand_wide >= limit_wide) begin
               done_in      = 1'b1;
               res_prime_in = '0;
               res_fin_in   = 1'b1;
               state_in     = ST_EMIT;
            end else begin
               stop_in   = 1'b0;
               found_in  = 1'b0;
               rd_idx_in = CNT_W'(1);
               state_in  = ST_TEST;
            end
         end
         ST_TEST: begin
            if (issue) begin
               rd_idx_in = rd_idx_ff + CNT_W'(1);
            end else if (pipe_empty) begin
               cand_in  = cand_next;
               digit_in = digit_next;
               if (found_ff) begin
                  state_in = ST_CHECK;
               end else begin
                  if (count_ff < CNT_W'(TABLE_DEPTH)) begin
                     tbl_wr_en = 1'b1;
                     count_in  = count_ff + CNT_W'(1);
                  end
                  res_prime_in = cand_wide[LIMIT_W-1:0];
                  res_fin_in   = 1'b0;
                  state_in     = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_prime_ff;
               rsp_fin_in   = res_fin_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seed_ff      <= 2'd0;
         done_ff      <= 1'b0;
         cand_ff      <= W'(FIRST_CANDIDATE);
         digit_ff     <= DIGIT_SEVEN;
         count_ff     <= CNT_W'(SEED_COUNT);
         stop_ff      <= 1'b0;
         found_ff     <= 1'b0;
         limit_ff     <= LIMIT_W'(LIMIT_RESET);
         valid_b_ff   <= 1'b0;
         valid_c_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seed_ff      <= seed_in;
         done_ff      <= done_in;
         cand_ff      <= cand_in;
         digit_ff     <= digit_in;
         count_ff     <= count_in;
         stop_ff      <= stop_in;
         found_ff     <= found_in;
         if (csr_wr_en) begin
            limit_ff <= csr_wr_data;
         end
         valid_b_ff   <= issue;
         valid_c_ff   <= valid_b_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_idx_ff     <= rd_idx_in;
      res_prime_ff  <= res_prime_in;
      res_fin_ff    <= res_fin_in;
      seed_sel_b_ff <= seed_sel;
      p_c_ff        <= p_b;
      sq_c_ff       <= (2*W)'(p_b) * (2*W)'(p_b);
      rsp_data_ff   <= rsp_data_in;
      rsp_fin_ff    <= rsp_fin_in;
   end

   // prime table
   always_ff @(posedge clock) begin
      if (tbl_wr_en) begin
         mem[count_ff[ADDR_W-1:0]] <= cand_ff;
      end
      mem_rd_ff <= mem[rd_idx_ff[ADDR_W-1:0]];
   end

   ptd_div_chain #(
      .WIDTH(W)
   ) u_chain (
      .clock     (clock),
      .reset     (reset),
      .dividend  (cand_ff),
      .in_valid  (chain_in_valid),
      .in_divisor(p_c_ff),
      .status    (chain_status)
   );

   `PTD_ASSERT_SAME(a_fin_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0, "finished item carries nonzero prime")
   `PTD_ASSERT_NEXT(a_cand_hold, clock, reset, chain_status.busy, $stable(cand_ff), "candidate moved while divisors in flight")
   `PTD_ASSERT_NEXT(a_count_step, clock, reset, tbl_wr_en, count_ff == $past(count_ff) + CNT_W'(1), "table count did not follow a store")

endmodule

/* sim/tb_prime_generator_trial_division.sv */
module tb_prime_generator_trial_division;
   timeunit 1ns;
   timeprecision 1ps;

   import ptd_pkg::*;

   localparam int TABLE_DEPTH = 256;
   localparam int NUMBER_WIDTH = 24;
   localparam longint unsigned NUMBER_MAX = (64'd1 << NUMBER_WIDTH) - 1;
   localparam int CYCLE_LIMIT = 3_000_000;
   localparam int RANDOM_ITEMS = 300;
   localparam int FILL_RUN = TABLE_DEPTH + 16;
   localparam int HOLD_CYCLES = 600;
   localparam int DRAIN_CYCLES = 64;
   localparam int N_DIRECTED = 25;
   localparam int NO_WRITE = -1;

   typedef struct {
      logic [23:0] prime;
      logic        fin;
   } prime_result_type;

   typedef struct {
      int          limit_write;
      logic        restart;
      bit          typed;
      logic [23:0] prime;
      logic        fin;
   } request_row_type;

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [23:0] csr_wr_data;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [23:0] rsp_tdata;
   logic [0:0]  rsp_tuser;

   // predictor state
   logic [23:0]     limit_now;
   longint unsigned next_candidate;
   longint unsigned found_primes [TABLE_DEPTH];
   int unsigned     stored_primes;
   int unsigned     seeds_given;
   bit              sequence_done;

   prime_result_type expected_primes [$];

   bit idle_enable;
   bit hold_request;
   int hold_left;
   int error_count = 0;
   int items_sent;
   int primes_checked = 0;
   int finished_seen = 0;
   int peak_stored;
   int cycle_count = 0;

   request_row_type directed_rows [0:N_DIRECTED-1] = '{
      '{NO_WRITE, 1'b0, 1'b1, 24'd2, 1'b0},
      '{NO_WRITE, 1'b0, 1'b1, 24'd3, 1'b0},
      '{NO_WRITE, 1'b0, 1'b1, 24'd5, 1'b0},
      '{NO_WRITE, 1'b0, 1'b0, 24'd0, 1'b0},
      '{NO_WRITE, 1'b0, 1'b0, 24'd0, 1'b0},
      '{NO_WRITE, 1'b1, 1'b1, 24'd2, 1'b0},
      '{NO_WRITE, 1'b0, 1'b1, 24'd3, 1'b0},
      '{1,        1'b1, 1'b1, 24'd2, 1'b0},
      '{NO_WRITE, 1'b0, 1'b1, 24'd3, 1'b0},
      '{NO_WRITE, 1'b0, 1'b1, 24'd5, 1'b0},
      '{NO_WRITE, 1'b0, 1'b1, 24'd0, 1'b1},
      '{24'hFFFFFF, 1'b0, 1'b1, 24'd0, 1'b1},
      '{NO_WRITE, 1'b1, 1'b1, 24'd2, 1'b0},
      '{NO_WRITE, 1'b0, 1'b1, 24'd3, 1'b0},
      '{NO_WRITE, 1'b0, 1'b1, 24'd5, 1'b0},
      '{NO_WRITE, 1'b0, 1'b0, 24'd0, 1'b0},
      '{8,        1'b1, 1'b1, 24'd2, 1'b0},
      '{NO_WRITE, 1'b0, 1'b1, 24'd3, 1'b0},
      '{NO_WRITE, 1'b0, 1'b1, 24'd5, 1'b0},
      '{NO_WRITE, 1'b0, 1'b0, 24'd0, 1'b0},
      '{NO_WRITE, 1'b0, 1'b1, 24'd0, 1'b1},
      '{7,        1'b1, 1'b1, 24'd2, 1'b0},
      '{NO_WRITE, 1'b0, 1'b1, 24'd3, 1'b0},
      '{NO_WRITE, 1'b0, 1'b1, 24'd5, 1'b0},
      '{NO_WRITE, 1'b0, 1'b1, 24'd0, 1'b1}
   };

   prime_generator_trial_division #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .NUMBER_WIDTH (NUMBER_WIDTH)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   function automatic void restart_sequence_model();
      found_primes[0] = 2;
      found_primes[1] = 3;
      found_primes[2] = 5;
      stored_primes = 3;
      next_candidate = FIRST_CANDIDATE;
      seeds_given = 0;
      sequence_done = 1'b0;
   endfunction

   function automatic bit has_small_factor(input longint unsigned n);
      longint unsigned p;
      for (int i = 1; i < stored_primes; i++) begin
         p = found_primes[i];
         if (p * p > n) return 1'b0;
         if (n % p == 0) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic prime_result_type compute_next_prime(input logic restart);
      prime_result_type res;
      longint unsigned  c;
      longint unsigned  step;
      bit               found;
      res.prime = '0;
      res.fin = 1'b0;
      found = 1'b0;
      if (restart) restart_sequence_model();
      if (seeds_given < SEED_COUNT) begin
         res.prime = found_primes[seeds_given][23:0];
         seeds_given++;
      end else begin
         while (!sequence_done && !found) begin
            c = next_candidate;
            if (c >= limit_now) begin
               sequence_done = 1'b1;
            end else begin
               step = c + ((c % 10 == DIGIT_THREE) ? 4 : 2);
               next_candidate = (step > NUMBER_MAX) ? NUMBER_MAX : step;
               if (!has_small_factor(c)) begin
                  if (stored_primes < TABLE_DEPTH) begin
                     found_primes[stored_primes] = c;
                     stored_primes++;
                  end
                  res.prime = c[23:0];
                  found = 1'b1;
               end
            end
         end
         if (sequence_done) begin
            res.prime = '0;
            res.fin = 1'b1;
         end
      end
      if (stored_primes > peak_stored) peak_stored = stored_primes;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [23:0] got,
                                  input logic [23:0] want);
      error_count++;
      if (error_count <= 40)
         $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got,
                  want);
   endtask

   task automatic write_limit(input logic [23:0] value);
      req_tvalid <= 1'b0;
      while (expected_primes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      limit_now = value;
   endtask

   task automatic send_item(input logic restart, input bit typed, input logic [23:0] prime,
                            input logic fin);
      prime_result_type predicted;
      if (idle_enable) begin
         while ($urandom_range(99) < 30) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata <= {7'd0, restart};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = compute_next_prime(restart);
      if (typed) begin
         predicted.prime = prime;
         predicted.fin = fin;
      end
      expected_primes.push_back(predicted);
      items_sent++;
   endtask

   // result side: check, then pick next ready
   initial begin : result_side
      prime_result_type want;
      bit               hold_taken;
      rsp_tready = 1'b0;
      hold_left = 0;
      hold_taken = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (expected_primes.size() == 0) begin
               report_mismatch("unexpected item", rsp_tdata, 24'd0);
            end else begin
               want = expected_primes.pop_front();
               primes_checked++;
               if (rsp_tuser[0]) finished_seen++;
               if (rsp_tdata !== want.prime) report_mismatch("prime", rsp_tdata, want.prime);
               if (rsp_tuser[0] !== want.fin)
                  report_mismatch("finished", {23'd0, rsp_tuser[0]}, {23'd0, want.fin});
            end
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (hold_request && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left = HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= !(idle_enable && $urandom_range(99) < 30);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("tb_prime_generator_trial_division: errors");
         $finish;
      end
   end

   initial begin : request_side
      int random_sent;
      int phase;
      int runs;
      int run_len;
      logic [23:0] limit_pick;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      idle_enable = 1'b1;
      hold_request = 1'b0;
      items_sent = 0;
      peak_stored = 0;
      random_sent = 0;
      phase = 0;
      limit_now = LIMIT_RESET;
      restart_sequence_model();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < N_DIRECTED; r++) begin
         if (directed_rows[r].limit_write != NO_WRITE)
            write_limit(24'(directed_rows[r].limit_write));
         send_item(directed_rows[r].restart, directed_rows[r].typed, directed_rows[r].prime,
                   directed_rows[r].fin);
      end

      // restart-led runs of requests under assorted limits
      while (random_sent < RANDOM_ITEMS) begin
         case ($urandom_range(9))
            0: limit_pick = 24'($urandom_range(1, 20));
            1, 2, 3, 4: limit_pick = 24'($urandom_range(21, 600));
            5, 6: limit_pick = 24'($urandom_range(601, 3000));
            7: limit_pick = 24'(LIMIT_RESET);
            8: limit_pick = 24'hFFFFFF;
            default: limit_pick = 24'($urandom_range(1, 24'hFFFFFF));
         endcase
         write_limit(limit_pick);
         if (phase == 1) hold_request = 1'b1;
         idle_enable = (phase != 2);
         runs = $urandom_range(1, 3);
         for (int k = 0; k < runs; k++) begin
            send_item(1'b1, 1'b0, '0, 1'b0);
            run_len = $urandom_range(0, 60);
            for (int j = 0; j < run_len; j++)
               send_item($urandom_range(99) < 5, 1'b0, '0, 1'b0);
            random_sent += run_len + 1;
         end
         idle_enable = 1'b1;
         phase++;
      end

      // one long run past a full prime table, no idling
      write_limit(24'hFFFFFF);
      idle_enable = 1'b0;
      send_item(1'b1, 1'b0, '0, 1'b0);
      for (int j = 0; j < FILL_RUN; j++) send_item(1'b0, 1'b0, '0, 1'b0);
      idle_enable = 1'b1;

      req_tvalid <= 1'b0;
      while (expected_primes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("%0d requests over %0d limit phases, %0d items checked, %0d with finished set",
               items_sent, phase + 1, primes_checked, finished_seen);
      $display("prime table reached %0d of %0d entries, %0d mismatches", peak_stored,
               TABLE_DEPTH, error_count);
      if (error_count == 0) begin
         $display("tb_prime_generator_trial_division: clean");
      end else begin
         $display("tb_prime_generator_trial_division: errors");
      end
      $finish;
   end

endmodule
